// ===== rtl/core/log2_wait_time_histogram_assert.svh =====
// Assertion macros shared by the checkers of the log2 wait time histogram.
`ifndef LOG2_WAIT_TIME_HISTOGRAM_ASSERT_SVH
`define LOG2_WAIT_TIME_HISTOGRAM_ASSERT_SVH

// Implication in the same cycle, disabled while reset is high.
`define LWH_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("Histogram assertion failed.");

// Implication after a fixed number of cycles, disabled while reset is high.
`define LWH_ASSERT_AFTER(label, ante, n, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##n (cons)) \
    else $error("Histogram assertion failed.");

// Implication that is also checked during reset.
`define LWH_ASSERT_ALWAYS(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |-> (cons)) \
    else $error("Histogram assertion failed.");

`endif

// ===== rtl/core/lwh_pkg.sv =====
// Package with the constants, types and threshold function of the histogram.
`default_nettype none

package lwh_pkg;

  localparam int NUM_BINS      = 64;
  localparam int COUNT_WIDTH   = 40;
  localparam int FRACTION_BITS = 16;
  localparam int TIME_W        = 64;
  localparam int LEAD_W        = 6;
  localparam int BIN_OUT_W     = 6;
  localparam int CFG_W         = 7;
  localparam int ADDR_W        = $clog2(NUM_BINS);
  localparam int BIN_CALC_W    = LEAD_W + 1;

  localparam logic [CFG_W-1:0]       CFG_RESET  = CFG_W'(64);
  localparam logic [TIME_W-1:0]      SQRT2_MANT = 64'hB504_F333_F9DE_6485;
  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX  = '1;

  localparam logic CMD_RECORD = 1'b0;
  localparam logic CMD_READ   = 1'b1;

  typedef struct packed {
    logic                 valid;
    logic                 cmd;
    logic                 inh;
    logic [BIN_OUT_W-1:0] rb;
  } item_t;

  typedef struct packed {
    logic                 valid;
    logic                 cmd;
    logic                 count;
    logic                 inrange;
    logic                 inh;
    logic [BIN_OUT_W-1:0] bin;
  } req_t;

  typedef struct packed {
    logic                   valid;
    logic                   counted;
    logic [BIN_OUT_W-1:0]   bin;
    logic [COUNT_WIDTH-1:0] normal;
    logic [COUNT_WIDTH-1:0] inherent;
  } res_t;

  // Smallest time with its leading one at position p that rounds up a bin.
  function automatic logic [TIME_W-1:0] sqrt2_thr(input int p);
    logic [TIME_W-1:0] quo;
    logic [TIME_W-1:0] rem;
    logic [TIME_W-1:0] mask;
    mask = (TIME_W'(1) << (TIME_W - 1 - p)) - TIME_W'(1);
    quo  = SQRT2_MANT >> (TIME_W - 1 - p);
    rem  = SQRT2_MANT & mask;
    return quo + ((rem != '0) ? TIME_W'(1) : TIME_W'(0));
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/lwh_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none

module lwh_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== rtl/core/lwh_bin_calc.sv =====
// Bin selection stage: leading-one search, rounding compare and range check.
`default_nettype none

module lwh_bin_calc (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire lwh_pkg::item_t                  item,
  input  wire logic [lwh_pkg::TIME_W-1:0]      wait_time,
  input  wire logic [lwh_pkg::CFG_W-1:0]       bins_in_use,
  output lwh_pkg::req_t                        req
);

  logic [lwh_pkg::TIME_W-1:0] thr [lwh_pkg::TIME_W];

  for (genvar i = 0; i < lwh_pkg::TIME_W; i++) begin : g_thr
    assign thr[i] = lwh_pkg::sqrt2_thr(i);
  end

  logic [lwh_pkg::LEAD_W-1:0] lead_next;

  always_comb begin
    lead_next = '0;
    for (int i = 0; i < lwh_pkg::TIME_W; i++) begin
      if (wait_time[i]) begin
        lead_next = lwh_pkg::LEAD_W'(i);
      end
    end
  end

  lwh_pkg::item_t             s1;
  logic [lwh_pkg::TIME_W-1:0] s1_time;
  logic [lwh_pkg::LEAD_W-1:0] s1_lead;
  logic                       s1_below;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1.valid <= 1'b0;
    end else begin
      s1.valid <= item.valid;
    end
    s1.cmd   <= item.cmd;
    s1.inh   <= item.inh;
    s1.rb    <= item.rb;
    s1_time  <= wait_time;
    s1_lead  <= lead_next;
    s1_below <= (wait_time >> lwh_pkg::FRACTION_BITS) == '0;
  end

  logic                             up;
  logic [lwh_pkg::BIN_CALC_W-1:0]   bin_full;
  logic [lwh_pkg::CFG_W-1:0]        eff;
  logic                             drop;

  always_comb begin
    up = s1_time >= thr[s1_lead];
    if (s1_below) begin
      bin_full = '0;
    end else begin
      bin_full = {1'b0, s1_lead} - lwh_pkg::BIN_CALC_W'(lwh_pkg::FRACTION_BITS)
                 + lwh_pkg::BIN_CALC_W'(up);
    end
    if (bins_in_use == '0) begin
      eff = lwh_pkg::CFG_W'(1);
    end else if (bins_in_use > lwh_pkg::CFG_W'(lwh_pkg::NUM_BINS)) begin
      eff = lwh_pkg::CFG_W'(lwh_pkg::NUM_BINS);
    end else begin
      eff = bins_in_use;
    end
    drop = lwh_pkg::CFG_W'(bin_full) >= eff;

    req.valid = s1.valid;
    req.cmd   = s1.cmd;
    req.inh   = s1.inh;
    if (s1.cmd == lwh_pkg::CMD_READ) begin
      req.count   = 1'b0;
      req.bin     = s1.rb;
      req.inrange = lwh_pkg::CFG_W'(s1.rb) < lwh_pkg::CFG_W'(lwh_pkg::NUM_BINS);
    end else begin
      req.count   = !drop;
      req.bin     = drop ? '0 : bin_full[lwh_pkg::BIN_OUT_W-1:0];
      req.inrange = 1'b1;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/lwh_counter_bank.sv =====
// Counter store of both banks with read-modify-write and write forwarding.
`default_nettype none

module lwh_counter_bank (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire lwh_pkg::req_t req,
  output lwh_pkg::res_t      res
);

  localparam int DW = 2 * lwh_pkg::COUNT_WIDTH;

  logic                          wr_en;
  logic [lwh_pkg::ADDR_W-1:0]    wr_addr;
  logic [DW-1:0]                 wr_data;
  logic [DW-1:0]                 rd_data;

  lwh_ram #(
    .WIDTH (DW),
    .DEPTH (lwh_pkg::NUM_BINS)
  ) u_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .raddr (req.bin[lwh_pkg::ADDR_W-1:0]),
    .rdata (rd_data)
  );

  logic [lwh_pkg::NUM_BINS-1:0]    vbits;
  logic                            vbit_q;
  lwh_pkg::req_t                   s2;
  logic                            fwd_valid;
  logic [lwh_pkg::ADDR_W-1:0]      fwd_addr;
  logic [lwh_pkg::COUNT_WIDTH-1:0] fwd_n;
  logic [lwh_pkg::COUNT_WIDTH-1:0] fwd_i;

  logic                            hit;
  logic [lwh_pkg::COUNT_WIDTH-1:0] base_n;
  logic [lwh_pkg::COUNT_WIDTH-1:0] base_i;
  logic [lwh_pkg::COUNT_WIDTH-1:0] new_n;
  logic [lwh_pkg::COUNT_WIDTH-1:0] new_i;

  always_comb begin
    wr_addr = s2.bin[lwh_pkg::ADDR_W-1:0];
    hit     = fwd_valid && (fwd_addr == wr_addr);
    if (hit) begin
      base_n = fwd_n;
      base_i = fwd_i;
    end else if (vbit_q) begin
      base_n = rd_data[DW-1:lwh_pkg::COUNT_WIDTH];
      base_i = rd_data[lwh_pkg::COUNT_WIDTH-1:0];
    end else begin
      base_n = '0;
      base_i = '0;
    end
    new_n = base_n;
    new_i = base_i;
    if (s2.count && s2.inh && (base_i != lwh_pkg::COUNT_MAX)) begin
      new_i = base_i + lwh_pkg::COUNT_WIDTH'(1);
    end
    if (s2.count && !s2.inh && (base_n != lwh_pkg::COUNT_MAX)) begin
      new_n = base_n + lwh_pkg::COUNT_WIDTH'(1);
    end
    wr_en   = s2.valid && s2.count;
    wr_data = {new_n, new_i};

    res.valid = s2.valid;
    if (s2.cmd == lwh_pkg::CMD_READ) begin
      res.counted  = 1'b0;
      res.bin      = s2.bin;
      res.normal   = s2.inrange ? base_n : '0;
      res.inherent = s2.inrange ? base_i : '0;
    end else if (s2.count) begin
      res.counted  = 1'b1;
      res.bin      = s2.bin;
      res.normal   = new_n;
      res.inherent = new_i;
    end else begin
      res.counted  = 1'b0;
      res.bin      = '0;
      res.normal   = '0;
      res.inherent = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2.valid  <= 1'b0;
      fwd_valid <= 1'b0;
      vbits     <= '0;
    end else begin
      s2.valid  <= req.valid;
      fwd_valid <= wr_en;
      if (wr_en) begin
        vbits[wr_addr] <= 1'b1;
      end
    end
    s2.cmd     <= req.cmd;
    s2.count   <= req.count;
    s2.inrange <= req.inrange;
    s2.inh     <= req.inh;
    s2.bin     <= req.bin;
    vbit_q     <= vbits[req.bin[lwh_pkg::ADDR_W-1:0]];
    fwd_addr   <= wr_addr;
    fwd_n      <= new_n;
    fwd_i      <= new_i;
  end

endmodule

`default_nettype wire

// ===== rtl/core/log2_wait_time_histogram.sv =====
// Top level of the log2-binned wait time histogram with two counter banks.
//
// Input transactions are taken on start when busy is low. command selects
// a record (wait_time in fixed point with 16 fraction bits, is_inherent
// picks the bank) or a read of bin read_bin from both banks.
// Every transaction gives one result, shown for one cycle with done high.
// The receiver cannot stall; results are never held back.
// done and the result leave through an output register that follows the
// input, bin search and counter stage registers. Throughput is one
// transaction per cycle while busy is low: the bin search takes one stage,
// the counter RAM read takes one stage, and the increment and write-back of
// the next stage forward to a following transaction on the same bin.
// config_write loads bins_in_use from config_data; write it only when idle.
// Synchronous reset clears all counts through per-bin valid bits at once,
// sets bins_in_use to 64, and holds busy high until the cycle after reset.
`default_nettype none

module log2_wait_time_histogram (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               start,
  output logic                                    busy,
  input  wire logic                               command,
  input  wire logic [lwh_pkg::TIME_W-1:0]         wait_time,
  input  wire logic                               is_inherent,
  input  wire logic [lwh_pkg::BIN_OUT_W-1:0]      read_bin,
  input  wire logic                               config_write,
  input  wire logic [lwh_pkg::CFG_W-1:0]          config_data,
  output logic                                    done,
  output logic                                    counted,
  output logic [lwh_pkg::BIN_OUT_W-1:0]           bin_index,
  output logic [lwh_pkg::COUNT_WIDTH-1:0]         normal_count,
  output logic [lwh_pkg::COUNT_WIDTH-1:0]         inherent_count
);

  logic [lwh_pkg::CFG_W-1:0]  bins_in_use;
  lwh_pkg::item_t             s0;
  logic [lwh_pkg::TIME_W-1:0] s0_time;
  lwh_pkg::req_t              req;
  lwh_pkg::res_t              res;

  always_ff @(posedge clk) begin
    busy <= rst;
    if (rst) begin
      bins_in_use <= lwh_pkg::CFG_RESET;
      s0.valid    <= 1'b0;
      done        <= 1'b0;
    end else begin
      if (config_write) begin
        bins_in_use <= config_data;
      end
      s0.valid <= start && !busy;
      done     <= res.valid;
    end
    s0.cmd         <= command;
    s0.inh         <= is_inherent;
    s0.rb          <= read_bin;
    s0_time        <= wait_time;
    counted        <= res.counted;
    bin_index      <= res.bin;
    normal_count   <= res.normal;
    inherent_count <= res.inherent;
  end

  lwh_bin_calc u_bin_calc (
    .clk         (clk),
    .rst         (rst),
    .item        (s0),
    .wait_time   (s0_time),
    .bins_in_use (bins_in_use),
    .req         (req)
  );

  lwh_counter_bank u_counter_bank (
    .clk (clk),
    .rst (rst),
    .req (req),
    .res (res)
  );

endmodule

`default_nettype wire

// ===== rtl/core/lwh_checker.sv =====
// Port-level checker of the histogram and its bind to the top level.
`default_nettype none

`include "log2_wait_time_histogram_assert.svh"

module lwh_checker (
  input wire logic                               clk,
  input wire logic                               rst,
  input wire logic                               start,
  input wire logic                               busy,
  input wire logic                               done,
  input wire logic                               counted,
  input wire logic [lwh_pkg::COUNT_WIDTH-1:0]    normal_count,
  input wire logic [lwh_pkg::COUNT_WIDTH-1:0]    inherent_count
);

  logic accepted;
  assign accepted = start && !busy;

  `LWH_ASSERT_AFTER(a_result_follows, accepted, 4, done)

  `LWH_ASSERT_AFTER(a_no_spurious_result, !accepted, 4, !done)

  `LWH_ASSERT_NOW(a_counted_nonzero, done && counted, normal_count != '0 || inherent_count != '0)

  `LWH_ASSERT_ALWAYS(a_busy_after_reset, rst, ##1 busy)

endmodule

bind log2_wait_time_histogram lwh_checker u_lwh_checker (.*);

`default_nettype wire

// ===== tb/log2_wait_time_histogram_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench of the log2 wait time histogram with table and random transactions.
module log2_wait_time_histogram_tb;
  import lwh_pkg::*;

  localparam int PIPE_LATENCY    = 4;
  localparam int CYCLE_LIMIT     = 300000;
  localparam int RANDOM_SEGMENTS = 6;
  localparam int SEGMENT_ITEMS   = 150;
  localparam int ROW_COUNT       = 24;

  localparam logic [TIME_W-1:0]      ONE_TIME        = TIME_W'(1) << FRACTION_BITS;
  localparam logic [TIME_W-1:0]      ROOT2_MANT_CEIL = 64'hB504_F333_F9DE_6485;
  localparam logic [TIME_W-1:0]      T_MAX           = '1;
  localparam logic [TIME_W-1:0]      T_TOP           = 64'h8000_0000_0000_0000;
  localparam logic [TIME_W-1:0]      T_BELOW_ROOT2   = ROOT2_MANT_CEIL - 64'd1;
  localparam logic [COUNT_WIDTH-1:0] SAT_COUNT       = {COUNT_WIDTH{1'b1}};

  typedef struct packed {
    logic                 cmd;
    logic [TIME_W-1:0]    wtime;
    logic                 inh;
    logic [BIN_OUT_W-1:0] rbin;
  } hist_item_t;

  typedef struct packed {
    logic                   counted;
    logic [BIN_OUT_W-1:0]   bin;
    logic [COUNT_WIDTH-1:0] normal;
    logic [COUNT_WIDTH-1:0] inherent;
  } hist_result_t;

  typedef struct packed {
    logic             set_cfg;
    logic [CFG_W-1:0] cfg_value;
    hist_item_t       item;
    logic             has_exp;
    hist_result_t     exp_res;
  } hist_row_t;

  localparam hist_result_t NO_RESULT = '0;

  logic                   clk          = 1'b0;
  logic                   rst          = 1'b1;
  logic                   start        = 1'b0;
  logic                   command      = CMD_RECORD;
  logic [TIME_W-1:0]      wait_time    = '0;
  logic                   is_inherent  = 1'b0;
  logic [BIN_OUT_W-1:0]   read_bin     = '0;
  logic                   config_write = 1'b0;
  logic [CFG_W-1:0]       config_data  = CFG_RESET;
  logic                   busy;
  logic                   done;
  logic                   counted;
  logic [BIN_OUT_W-1:0]   bin_index;
  logic [COUNT_WIDTH-1:0] normal_count;
  logic [COUNT_WIDTH-1:0] inherent_count;

  hist_result_t           pending_results[$];
  hist_result_t           oldest_result;
  hist_row_t              stim_rows[ROW_COUNT];
  logic [CFG_W-1:0]       model_bins_in_use = CFG_RESET;
  logic [COUNT_WIDTH-1:0] model_normal[NUM_BINS];
  logic [COUNT_WIDTH-1:0] model_inherent[NUM_BINS];
  int                     mismatches      = 0;
  int                     cycle_count     = 0;
  int                     sender_idle_pct = 0;
  int                     burst_left      = 0;

  log2_wait_time_histogram dut (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .command        (command),
    .wait_time      (wait_time),
    .is_inherent    (is_inherent),
    .read_bin       (read_bin),
    .config_write   (config_write),
    .config_data    (config_data),
    .done           (done),
    .counted        (counted),
    .bin_index      (bin_index),
    .normal_count   (normal_count),
    .inherent_count (inherent_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic int rounded_log2_bin(input logic [TIME_W-1:0] w);
    int lead;
    logic [TIME_W-1:0] mant;
    lead = TIME_W - 1;
    if (w < ONE_TIME) return 0;
    while (!w[lead]) lead--;
    mant = w << (TIME_W - 1 - lead);
    return lead - FRACTION_BITS + ((mant >= ROOT2_MANT_CEIL) ? 1 : 0);
  endfunction

  function automatic hist_result_t histogram_step(input hist_item_t it);
    hist_result_t res;
    int kept;
    int k;
    res = '0;
    if (it.cmd == CMD_READ) begin
      res.bin      = it.rbin;
      res.normal   = model_normal[it.rbin];
      res.inherent = model_inherent[it.rbin];
      return res;
    end
    if (model_bins_in_use == '0) begin
      kept = 1;
    end else if (int'(model_bins_in_use) > NUM_BINS) begin
      kept = NUM_BINS;
    end else begin
      kept = int'(model_bins_in_use);
    end
    k = rounded_log2_bin(it.wtime);
    if (k >= kept) return res;
    if (it.inh) begin
      if (model_inherent[k] != SAT_COUNT) model_inherent[k] = model_inherent[k] + COUNT_WIDTH'(1);
    end else begin
      if (model_normal[k] != SAT_COUNT) model_normal[k] = model_normal[k] + COUNT_WIDTH'(1);
    end
    res.counted  = 1'b1;
    res.bin      = BIN_OUT_W'(k);
    res.normal   = model_normal[k];
    res.inherent = model_inherent[k];
    return res;
  endfunction

  function automatic hist_item_t random_item();
    hist_item_t it;
    int lead;
    it.cmd  = ($urandom_range(99) < 25) ? CMD_READ : CMD_RECORD;
    it.inh  = 1'($urandom_range(1));
    it.rbin = ($urandom_range(1) == 1) ? BIN_OUT_W'($urandom_range(20))
                                       : BIN_OUT_W'($urandom_range(63));
    lead = $urandom_range(TIME_W - 1, FRACTION_BITS);
    case ($urandom_range(9))
      0: it.wtime = TIME_W'($urandom_range(16'hFFFF));
      1: it.wtime = (ROOT2_MANT_CEIL >> (TIME_W - 1 - lead)) + TIME_W'($urandom_range(3))
                    - TIME_W'(1);
      2: it.wtime = TIME_W'(1) << $urandom_range(TIME_W - 1);
      default: it.wtime = {$urandom, $urandom} >> $urandom_range(TIME_W - 1);
    endcase
    return it;
  endfunction

  task automatic report_mismatch(input string field, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("Mismatch in %s at cycle %0d: got %0h, expected %0h",
             field, cycle_count, got, want);
    mismatches++;
  endtask

  task automatic drive_item(input hist_item_t it, input logic has_exp,
                            input hist_result_t exp_res);
    hist_result_t predicted;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      if ($urandom_range(49) == 0) burst_left = $urandom_range(30, 10);
      while (sender_idle_pct > 0 && burst_left == 0 && $urandom_range(99) < sender_idle_pct) begin
        start <= 1'b0;
        @(posedge clk);
      end
    end
    start       <= 1'b1;
    command     <= it.cmd;
    wait_time   <= it.wtime;
    is_inherent <= it.inh;
    read_bin    <= it.rbin;
    do @(posedge clk); while (busy);
    predicted = histogram_step(it);
    pending_results = {pending_results, (has_exp ? exp_res : predicted)};
  endtask

  task automatic drain_results();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (PIPE_LATENCY + 2) @(posedge clk);
  endtask

  task automatic write_bins_in_use(input logic [CFG_W-1:0] value);
    config_write <= 1'b1;
    config_data  <= value;
    @(posedge clk);
    config_write <= 1'b0;
    model_bins_in_use = value;
  endtask

  always @(posedge clk) begin
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with no transaction pending", 64'(bin_index), 64'd0);
      end else begin
        oldest_result = pending_results.pop_front();
        if (counted !== oldest_result.counted)
          report_mismatch("counted", 64'(counted), 64'(oldest_result.counted));
        if (bin_index !== oldest_result.bin)
          report_mismatch("bin_index", 64'(bin_index), 64'(oldest_result.bin));
        if (normal_count !== oldest_result.normal)
          report_mismatch("normal_count", 64'(normal_count), 64'(oldest_result.normal));
        if (inherent_count !== oldest_result.inherent)
          report_mismatch("inherent_count", 64'(inherent_count), 64'(oldest_result.inherent));
      end
    end
  end

  initial begin
    logic [CFG_W-1:0] seg_cfg;
    for (int i = 0; i < NUM_BINS; i++) begin
      model_normal[i]   = '0;
      model_inherent[i] = '0;
    end
    stim_rows = '{
      '{1'b0, 7'd0, '{CMD_READ, 64'h0, 1'b0, 6'd0}, 1'b1, '{1'b0, 6'd0, 40'd0, 40'd0}},
      '{1'b0, 7'd0, '{CMD_READ, T_MAX, 1'b1, 6'd63}, 1'b1, '{1'b0, 6'd63, 40'd0, 40'd0}},
      '{1'b0, 7'd0, '{CMD_RECORD, 64'h0, 1'b0, 6'd63}, 1'b1, '{1'b1, 6'd0, 40'd1, 40'd0}},
      '{1'b0, 7'd0, '{CMD_RECORD, 64'hFFFF, 1'b1, 6'd0}, 1'b1, '{1'b1, 6'd0, 40'd1, 40'd1}},
      '{1'b0, 7'd0, '{CMD_RECORD, 64'h1_0000, 1'b0, 6'd0}, 1'b0, NO_RESULT},
      '{1'b0, 7'd0, '{CMD_RECORD, 64'h1_6A09, 1'b0, 6'd0}, 1'b0, NO_RESULT},
      '{1'b0, 7'd0, '{CMD_RECORD, 64'h1_6A0A, 1'b1, 6'd0}, 1'b0, NO_RESULT},
      '{1'b0, 7'd0, '{CMD_RECORD, 64'h1_FFFF, 1'b0, 6'd0}, 1'b0, NO_RESULT},
      '{1'b0, 7'd0, '{CMD_RECORD, 64'h2_0000, 1'b1, 6'd0}, 1'b0, NO_RESULT},
      '{1'b0, 7'd0, '{CMD_RECORD, T_BELOW_ROOT2, 1'b0, 6'd0}, 1'b0, NO_RESULT},
      '{1'b0, 7'd0, '{CMD_RECORD, ROOT2_MANT_CEIL, 1'b1, 6'd0}, 1'b0, NO_RESULT},
      '{1'b0, 7'd0, '{CMD_RECORD, T_MAX, 1'b0, 6'd63}, 1'b0, NO_RESULT},
      '{1'b0, 7'd0, '{CMD_RECORD, T_TOP, 1'b1, 6'd0}, 1'b0, NO_RESULT},
      '{1'b0, 7'd0, '{CMD_READ, T_MAX, 1'b1, 6'd48}, 1'b0, NO_RESULT},
      '{1'b0, 7'd0, '{CMD_READ, 64'h0, 1'b0, 6'd47}, 1'b0, NO_RESULT},
      '{1'b0, 7'd0, '{CMD_READ, 64'h2_0000, 1'b1, 6'd1}, 1'b0, NO_RESULT},
      '{1'b1, 7'd0, '{CMD_RECORD, 64'h2_0000, 1'b0, 6'd0}, 1'b1, NO_RESULT},
      '{1'b0, 7'd0, '{CMD_RECORD, 64'hFFFF, 1'b1, 6'd0}, 1'b0, NO_RESULT},
      '{1'b1, 7'd1, '{CMD_RECORD, T_MAX, 1'b0, 6'd0}, 1'b1, NO_RESULT},
      '{1'b1, 7'd127, '{CMD_RECORD, T_MAX, 1'b1, 6'd0}, 1'b0, NO_RESULT},
      '{1'b1, 7'd48, '{CMD_RECORD, T_MAX, 1'b0, 6'd0}, 1'b1, NO_RESULT},
      '{1'b0, 7'd0, '{CMD_RECORD, T_BELOW_ROOT2, 1'b0, 6'd0}, 1'b0, NO_RESULT},
      '{1'b1, 7'd64, '{CMD_READ, 64'h0, 1'b0, 6'd48}, 1'b0, NO_RESULT},
      '{1'b0, 7'd0, '{CMD_READ, T_MAX, 1'b1, 6'd0}, 1'b0, NO_RESULT}
    };

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    foreach (stim_rows[i]) begin
      if (stim_rows[i].set_cfg) begin
        drain_results();
        write_bins_in_use(stim_rows[i].cfg_value);
      end
      drive_item(stim_rows[i].item, stim_rows[i].has_exp, stim_rows[i].exp_res);
    end

    for (int seg = 0; seg < RANDOM_SEGMENTS; seg++) begin
      case (seg)
        0: seg_cfg = 7'd64;
        1: seg_cfg = CFG_W'($urandom_range(48, 2));
        2: seg_cfg = 7'd0;
        3: seg_cfg = 7'd127;
        4: seg_cfg = 7'd1;
        default: seg_cfg = CFG_W'($urandom_range(127));
      endcase
      sender_idle_pct = (seg < 2) ? 38 : (seg < 4) ? 57 : 0;
      burst_left = 0;
      drain_results();
      write_bins_in_use(seg_cfg);
      for (int n = 0; n < SEGMENT_ITEMS; n++) drive_item(random_item(), 1'b0, NO_RESULT);
    end

    drain_results();
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
